### rtl/qvr_pkg.sv
// Shared constants for the quaternion vector rotate block.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

    localparam int NCOMP = 4;

    // Hamilton product: res[i] = sum_j (+/-) L[j] * R[HAM_IDX[i][j]].
    localparam int HAM_IDX [NCOMP][NCOMP] = '{
        '{0, 1, 2, 3}, '{1, 0, 3, 2}, '{2, 3, 0, 1}, '{3, 2, 1, 0}};
    localparam bit HAM_NEG [NCOMP][NCOMP] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b0}};

endpackage
`default_nettype wire

### rtl/qvr_prod.sv
// Product stages: q*d, then (q*d)*conj(q), squared norm and magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module qvr_prod #(
    parameter int W = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_vld,
    input  wire signed [W-1:0]        i_dir [qvr_pkg::NCOMP],
    input  wire signed [W-1:0]        i_rot [qvr_pkg::NCOMP],
    output logic                      o_vld,
    output logic                      o_neg [qvr_pkg::NCOMP],
    output logic [3*W+5:0]            o_mag [qvr_pkg::NCOMP],
    output logic [2*W:0]              o_den,
    output logic                      o_zero
);

    localparam int TW = 2*W+3;
    localparam int RW = 3*W+6;

    logic                 r_a_vld;
    logic signed [TW-1:0] r_a_t [qvr_pkg::NCOMP];
    logic signed [W:0]    r_a_qc [qvr_pkg::NCOMP];
    logic [2*W:0]         r_a_n2;
    logic                 r_a_zero;

    logic signed [TW-1:0] n_a_t [qvr_pkg::NCOMP];
    logic signed [W:0]    n_a_qc [qvr_pkg::NCOMP];
    logic [2*W:0]         n_a_n2;
    logic                 n_a_zero;

    logic                 r_b_vld;
    logic signed [RW-1:0] r_b_r [qvr_pkg::NCOMP];
    logic [2*W:0]         r_b_n2;
    logic                 r_b_zero;
    logic signed [RW-1:0] n_b_r [qvr_pkg::NCOMP];

    always_comb begin
        logic signed [TW-1:0]  p;
        logic signed [2*W+1:0] sq;
        logic signed [2*W+1:0] acc;
        acc = '0;
        n_a_zero = 1'b1;
        for (int i = 0; i < qvr_pkg::NCOMP; i++) begin
            n_a_t[i] = '0;
            for (int j = 0; j < qvr_pkg::NCOMP; j++) begin
                p = i_rot[j] * i_dir[qvr_pkg::HAM_IDX[i][j]];
                n_a_t[i] = qvr_pkg::HAM_NEG[i][j] ? n_a_t[i] - p : n_a_t[i] + p;
            end
            sq = i_rot[i] * i_rot[i];
            acc = acc + sq;
            n_a_qc[i] = (i == 0) ? (W+1)'(i_rot[i]) : -(W+1)'(i_rot[i]);
            if (i_rot[i] != '0) begin
                n_a_zero = 1'b0;
            end
        end
        n_a_n2 = acc[2*W:0];
    end

    always_comb begin
        logic signed [RW-1:0] p;
        for (int i = 0; i < qvr_pkg::NCOMP; i++) begin
            n_b_r[i] = '0;
            for (int j = 0; j < qvr_pkg::NCOMP; j++) begin
                p = r_a_t[j] * r_a_qc[qvr_pkg::HAM_IDX[i][j]];
                n_b_r[i] = qvr_pkg::HAM_NEG[i][j] ? n_b_r[i] - p : n_b_r[i] + p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            o_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            o_vld   <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_t    <= n_a_t;
            r_a_qc   <= n_a_qc;
            r_a_n2   <= n_a_n2;
            r_a_zero <= n_a_zero;
            r_b_r    <= n_b_r;
            r_b_n2   <= r_a_n2;
            r_b_zero <= r_a_zero;
            for (int i = 0; i < qvr_pkg::NCOMP; i++) begin
                o_neg[i] <= r_b_r[i][RW-1];
                o_mag[i] <= r_b_r[i][RW-1] ? RW'(-r_b_r[i]) : RW'(r_b_r[i]);
            end
            o_den  <= r_b_n2;
            o_zero <= r_b_zero;
        end
    end

endmodule
`default_nettype wire

### rtl/qvr_div.sv
// Pipelined restoring divider with rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none
module qvr_div #(
    parameter int W = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_vld,
    input  wire                       i_neg [qvr_pkg::NCOMP],
    input  wire [3*W+5:0]             i_mag [qvr_pkg::NCOMP],
    input  wire [2*W:0]               i_den,
    input  wire                       i_zero,
    input  wire                       i_ready,
    output logic                      o_en,
    output logic                      o_vld,
    output logic signed [W-1:0]       o_res [qvr_pkg::NCOMP],
    output logic                      o_zero
);

    localparam int RW = 3*W+6;
    localparam int NW = RW+1;
    localparam int NS = W+2;

    logic [NW-1:0] r_rem  [NS][qvr_pkg::NCOMP];
    logic [W:0]    r_q    [NS][qvr_pkg::NCOMP];
    logic          r_ovf  [NS][qvr_pkg::NCOMP];
    logic          r_neg  [NS][qvr_pkg::NCOMP];
    logic [2*W:0]  r_den  [NS];
    logic          r_zero [NS];
    logic          r_vld  [NS];

    assign o_en = !o_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (o_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            for (int c = 0; c < qvr_pkg::NCOMP; c++) begin
                r_rem[0][c] <= {i_mag[c], 1'b0};
                r_ovf[0][c] <= {i_mag[c], 1'b0} >= (NW'(i_den) << (W+1));
                r_q[0][c]   <= '0;
                r_neg[0][c] <= i_neg[c];
            end
            r_den[0]  <= i_den;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_step
        localparam int K = W+1-s;
        logic [NW-1:0] w_dsh;
        assign w_dsh = NW'(r_den[s-1]) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (o_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (o_en) begin
                for (int c = 0; c < qvr_pkg::NCOMP; c++) begin
                    if (r_rem[s-1][c] >= w_dsh) begin
                        r_rem[s][c] <= r_rem[s-1][c] - w_dsh;
                        r_q[s][c]   <= r_q[s-1][c] | ((W+1)'(1) << K);
                    end else begin
                        r_rem[s][c] <= r_rem[s-1][c];
                        r_q[s][c]   <= r_q[s-1][c];
                    end
                    r_ovf[s][c] <= r_ovf[s-1][c];
                    r_neg[s][c] <= r_neg[s-1][c];
                end
                r_den[s]  <= r_den[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (o_en) begin
            o_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [W+1:0] rq;
        if (o_en) begin
            for (int c = 0; c < qvr_pkg::NCOMP; c++) begin
                rq = ({1'b0, r_q[NS-1][c]} + (W+2)'(1)) >> 1;
                if (r_zero[NS-1]) begin
                    o_res[c] <= '0;
                end else if (r_neg[NS-1][c]) begin
                    if (r_ovf[NS-1][c] || rq > ((W+2)'(1) << (W-1))) begin
                        o_res[c] <= {1'b1, {(W-1){1'b0}}};
                    end else begin
                        o_res[c] <= W'(-rq);
                    end
                end else begin
                    if (r_ovf[NS-1][c] || rq > (((W+2)'(1) << (W-1)) - (W+2)'(1))) begin
                        o_res[c] <= {1'b0, {(W-1){1'b1}}};
                    end else begin
                        o_res[c] <= W'(rq);
                    end
                end
            end
            o_zero <= r_zero[NS-1];
        end
    end

endmodule
`default_nettype wire

### rtl/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotate block.
//  Channel  Dir  Payload
//  s        in   tdata: dir_w, dir_x, dir_y, dir_z, rot_w, rot_x, rot_y, rot_z
//  m        out  tdata: out_w, out_x, out_y, out_z; tuser: zero_rotation
// One item per cycle unless the m side stalls (three product stages,
// COMP_WIDTH+2 divider steps, one output register).
// The divider takes one quotient bit per stage.
// Reset clears the valid bits only.
// A stall on the m side freezes every stage; o_s_tready drops with it.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate_top #(
    parameter int COMP_WIDTH = 16
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_s_tvalid,
    output logic                                     o_s_tready,
    // dir_w, dir_x, dir_y, dir_z, rot_w, rot_x, rot_y, rot_z
    input  wire [8*COMP_WIDTH-1:0]                   i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire                                      i_m_tready,
    // out_w, out_x, out_y, out_z, zero padding
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]        o_m_tdata,
    // zero_rotation
    output logic                                     o_m_tuser
);

    localparam int W  = COMP_WIDTH;
    localparam int OW = ((4*W+7)/8)*8;

    logic signed [W-1:0] w_dir [qvr_pkg::NCOMP];
    logic signed [W-1:0] w_rot [qvr_pkg::NCOMP];
    logic                w_vld;
    logic                w_neg [qvr_pkg::NCOMP];
    logic [3*W+5:0]      w_mag [qvr_pkg::NCOMP];
    logic [2*W:0]        w_den;
    logic                w_zero;
    logic                w_en;
    logic signed [W-1:0] w_res [qvr_pkg::NCOMP];
    logic [4*W-1:0]      w_flat;

    for (genvar c = 0; c < qvr_pkg::NCOMP; c++) begin : g_unpack
        assign w_dir[c] = i_s_tdata[c*W +: W];
        assign w_rot[c] = i_s_tdata[(c+4)*W +: W];
        assign w_flat[c*W +: W] = w_res[c];
    end

    assign o_s_tready = w_en;
    assign o_m_tdata  = OW'(w_flat);

    qvr_prod #(.W(W)) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_dir   (w_dir),
        .i_rot   (w_rot),
        .o_vld   (w_vld),
        .o_neg   (w_neg),
        .o_mag   (w_mag),
        .o_den   (w_den),
        .o_zero  (w_zero)
    );

    qvr_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld),
        .i_neg   (w_neg),
        .i_mag   (w_mag),
        .i_den   (w_den),
        .i_zero  (w_zero),
        .i_ready (i_m_tready),
        .o_en    (w_en),
        .o_vld   (o_m_tvalid),
        .o_res   (w_res),
        .o_zero  (o_m_tuser)
    );

endmodule
`default_nettype wire

### tb/tb_quaternion_vector_rotate_top.sv
// Self-checking testbench for the quaternion vector rotate block.
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate_top;

    localparam int CW = 16;
    localparam int LAT = CW + 6;
    localparam int WD_LIMIT = 5000;

    typedef struct packed {
        logic signed [CW-1:0] w, x, y, z;
        logic                 zr;
    } rot_out_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [8*CW-1:0] i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [4*CW-1:0] o_m_tdata;
    logic          o_m_tuser;

    rot_out_t rotated_q[$];
    int       n_errors = 0;
    int       idle_cycles = 0;
    int       sink_gap = 0;
    bit       sink_stall_en = 1'b1;
    bit       src_gap_en = 1'b1;

    quaternion_vector_rotate_top #(.COMP_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [CW-1:0] div_round_sat(logic signed [127:0] num,
                                                           logic signed [127:0] den);
        logic signed [127:0] mag, q, r;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if (2 * r >= den) q = q + 1;
        if (neg) begin
            if (q > (128'sd1 <<< (CW - 1))) q = 128'sd1 <<< (CW - 1);
            return -q;
        end
        if (q > (128'sd1 <<< (CW - 1)) - 1) q = (128'sd1 <<< (CW - 1)) - 1;
        return q;
    endfunction

    function automatic rot_out_t rotate_vector(logic [8*CW-1:0] data);
        logic signed [127:0] d[4], q[4], qc[4], t[4], r[4], n2;
        int idx[4][4], ng[4][4];
        rot_out_t res;
        idx = '{'{0, 1, 2, 3}, '{1, 0, 3, 2}, '{2, 3, 0, 1}, '{3, 2, 1, 0}};
        ng = '{'{0, 1, 1, 1}, '{0, 0, 0, 1}, '{0, 1, 0, 0}, '{0, 0, 1, 0}};
        n2 = 0;
        for (int i = 0; i < 4; i++) begin
            d[i] = $signed(data[i*CW +: CW]);
            q[i] = $signed(data[(4+i)*CW +: CW]);
            qc[i] = (i == 0) ? q[i] : -q[i];
            n2 += q[i] * q[i];
        end
        if (n2 == 0) begin
            res = '0;
            res.zr = 1'b1;
            return res;
        end
        for (int i = 0; i < 4; i++) begin
            t[i] = 0;
            for (int j = 0; j < 4; j++)
                t[i] += ng[i][j] ? -(q[j] * d[idx[i][j]]) : q[j] * d[idx[i][j]];
        end
        for (int i = 0; i < 4; i++) begin
            r[i] = 0;
            for (int j = 0; j < 4; j++)
                r[i] += ng[i][j] ? -(t[j] * qc[idx[i][j]]) : t[j] * qc[idx[i][j]];
        end
        res.w = div_round_sat(r[0], n2);
        res.x = div_round_sat(r[1], n2);
        res.y = div_round_sat(r[2], n2);
        res.z = div_round_sat(r[3], n2);
        res.zr = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic send_item(logic [8*CW-1:0] data);
        int gap;
        if (src_gap_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rotated_q.push_back(rotate_vector(data));
    endtask

    function automatic logic [8*CW-1:0] pack_item(int v[8]);
        logic [8*CW-1:0] data;
        for (int i = 0; i < 8; i++) data[i*CW +: CW] = v[i];
        return data;
    endfunction

    function automatic logic [8*CW-1:0] random_item();
        logic [8*CW-1:0] data;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
                0: data[i*CW +: CW] = $urandom;
                1: data[i*CW +: CW] = $urandom_range(0, 8192) - 4096;
                2: data[i*CW +: CW] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                default: data[i*CW +: CW] = $urandom_range(0, 64) - 32;
            endcase
        end
        if ($urandom_range(0, 15) == 0) data[8*CW-1:4*CW] = '0;
        return data;
    endfunction

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(pack_item('{4096, 0, 0, 0, 4096, 0, 0, 0}));
        send_item(pack_item('{0, 4096, 0, 0, 2896, 0, 0, 2896}));
        send_item(pack_item('{0, 4096, 4096, 0, 0, 0, 0, 0}));
        send_item(pack_item('{0, 32767, 32767, 32767, 1, 1, 1, 1}));
        send_item(pack_item('{0, 32767, 32767, 0, 3, 0, 0, 1}));
        send_item(pack_item('{0, -32768, -32768, 0, 3, 0, 0, 1}));
        send_item(pack_item('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}));
        send_item(pack_item('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
        send_item(pack_item('{-1, -1, -1, -1, -1, 0, 0, 0}));
        send_item(pack_item('{1, 1, 1, 1, 0, 0, 0, 1}));
        send_item(pack_item('{100, -200, 300, -400, 0, -32768, 0, 0}));
        send_item(pack_item('{-1, 1, -1, 1, 0, 0, 1, 0}));
        send_item(pack_item('{-1, 1, 1, 1, 1, 1, 1, 0}));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    task automatic test_hold_off();
        wait_drained();
        for (int i = 0; i < 8; i++) send_item(random_item());
    endtask

    task automatic test_full_rate(int n);
        src_gap_en = 1'b0;
        sink_stall_en = 1'b0;
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (sink_stall_en && sink_gap > 0) begin
            i_m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 11);
        end else begin
            i_m_tready <= 1'b1;
            sink_gap <= 0;
        end
    end

    always @(posedge i_clk) begin
        rot_out_t exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                exp_r = rotated_q.pop_front();
                if ($signed(o_m_tdata[0*CW +: CW]) != exp_r.w)
                    report_mismatch("out_w", $signed(o_m_tdata[0*CW +: CW]), exp_r.w);
                if ($signed(o_m_tdata[1*CW +: CW]) != exp_r.x)
                    report_mismatch("out_x", $signed(o_m_tdata[1*CW +: CW]), exp_r.x);
                if ($signed(o_m_tdata[2*CW +: CW]) != exp_r.y)
                    report_mismatch("out_y", $signed(o_m_tdata[2*CW +: CW]), exp_r.y);
                if ($signed(o_m_tdata[3*CW +: CW]) != exp_r.z)
                    report_mismatch("out_z", $signed(o_m_tdata[3*CW +: CW]), exp_r.z);
                if (o_m_tuser != exp_r.zr)
                    report_mismatch("zero_rotation", o_m_tuser, exp_r.zr);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("tb_quaternion_vector_rotate_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(240);
        test_hold_off();
        test_random(170);
        test_full_rate(80);
        wait_drained();
        repeat (LAT + 4) @(posedge i_clk);
        if (n_errors == 0 && rotated_q.size() == 0) begin
            $display("tb_quaternion_vector_rotate_top: PASS");
        end else begin
            $display("tb_quaternion_vector_rotate_top: FAIL");
        end
        $finish;
    end

endmodule
